/* sv/assert_macros.svh */
// Assertion macros shared by the identifier RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define MPI_ASSERT_CLK(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) else $error(msg);
`define MPI_ASSERT(lbl, prop, msg) \
  `MPI_ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`endif

/* sv/mpi_pkg.sv */
// Shared widths, codes and types of the motor parameter identifier.
`timescale 1ns / 1ps
`default_nettype none
package mpi_pkg;
  localparam int SAMPLE_W  = 16;
  localparam int RESULT_W  = 32;
  localparam int TIMER_W   = 24;
  localparam int VOLT_W    = 15;
  localparam int SETTLE_W  = 16;
  localparam int GAIN_W    = 32;
  localparam int CFG_IDX_W = 3;
  localparam int DIV_NUM_W = 48;
  localparam int DIV_DEN_W = 17;

  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_HALF  = 3'd1;
  localparam logic [2:0] PH_FULL  = 3'd2;
  localparam logic [2:0] PH_PAUSE = 3'd3;
  localparam logic [2:0] PH_LD    = 3'd4;
  localparam logic [2:0] PH_LQ    = 3'd5;
  localparam logic [2:0] PH_FLUX  = 3'd6;
  localparam logic [2:0] PH_DONE  = 3'd7;

  localparam logic [1:0] MODE_OFF  = 2'd0;
  localparam logic [1:0] MODE_LS   = 2'd1;
  localparam logic [1:0] MODE_LDLQ = 2'd2;
  localparam logic [1:0] MODE_FLUX = 2'd3;

  localparam logic [2:0] CFG_MODE   = 3'd0;
  localparam logic [2:0] CFG_INJECT = 3'd1;
  localparam logic [2:0] CFG_FLUXV  = 3'd2;
  localparam logic [2:0] CFG_SETTLE = 3'd3;
  localparam logic [2:0] CFG_GAIN   = 3'd4;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;
endpackage
`default_nettype wire

/* sv/mpi_div.sv */
// Iterative restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module mpi_div #(
  parameter int NUM_W = mpi_pkg::DIV_NUM_W,
  parameter int DEN_W = mpi_pkg::DIV_DEN_W
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic [NUM_W-1:0]    num,
  input  wire logic [DEN_W-1:0]    den,
  output mpi_pkg::div_stat_t       stat,
  output logic      [NUM_W-1:0]    quo
);
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] nq_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             done_r;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   rem_sub;
  logic             ge;
  logic [DEN_W-1:0] rem_nxt;

  always_comb begin
    rem_sh  = {rem_r, nq_r[NUM_W-1]};
    rem_sub = rem_sh - {1'b0, den_r};
    ge      = rem_sh >= {1'b0, den_r};
    rem_nxt = ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        nq_r  <= num;
        rem_r <= '0;
        den_r <= den;
        cnt_r <= CNT_W'(NUM_W);
      end else if (cnt_r != '0) begin
        nq_r  <= {nq_r[NUM_W-2:0], ge};
        rem_r <= rem_nxt;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = cnt_r != '0;
  assign stat.done = done_r;
  assign quo       = nq_r;

  `MPI_ASSERT(a_div_start_busy, start |=> stat.busy, "Divider did not start after request.")
  `MPI_ASSERT(a_div_done_idle, done_r |-> (cnt_r == '0), "Divider flagged done while running.")
endmodule
`default_nettype wire

/* sv/mpi_mul.sv */
// Shared 32 by 32 unsigned multiplier with a registered product.
`timescale 1ns / 1ps
`default_nettype none
module mpi_mul (
  input  wire logic        clk,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output logic      [63:0] p_r
);
  always_ff @(posedge clk) begin
    p_r <= {32'b0, a} * {32'b0, b};
  end
endmodule
`default_nettype wire

/* sv/motor_parameter_identifier.sv */
// Top level of the PMSM offline parameter identifier.
// A plain control step passes from S_STEP to S_OUT; an inductance step also passes
// through the multiply states S_M2, S_M3 and S_M4, and resistance and flux steps wait
// in S_DIV for the bit-serial divider. One word is in work at a time.
// Reset is synchronous and active low; it clears the sequence, the stored
// results and the configuration registers to their reset values (settle_r to 1000).
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module motor_parameter_identifier (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 in_start_req,
  input  wire logic signed [15:0]   in_current_d,
  input  wire logic signed [15:0]   in_current_q,
  input  wire logic signed [15:0]   in_elec_speed,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic signed [15:0]        out_volt_d_cmd,
  output logic signed [15:0]        out_volt_q_cmd,
  output logic [2:0]                out_phase,
  output logic                      out_done_res,
  output logic                      out_fault,
  output logic [31:0]               out_resistance,
  output logic [31:0]               out_induct_d,
  output logic [31:0]               out_induct_q,
  output logic signed [31:0]        out_flux_linkage,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [2:0]           cfg_index,
  input  wire logic [31:0]          cfg_data
);
  localparam int TW = mpi_pkg::TIMER_W;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_STEP   = 9'b000000010,
    S_M2     = 9'b000000100,
    S_M3     = 9'b000001000,
    S_M4     = 9'b000010000,
    S_F2     = 9'b000100000,
    S_DIV    = 9'b001000000,
    S_DIVEND = 9'b010000000,
    S_OUT    = 9'b100000000
  } st_t;

  typedef enum logic [5:0] {
    JOB_NONE = 6'b000001,
    JOB_RS   = 6'b000010,
    JOB_LDLQ = 6'b000100,
    JOB_LD   = 6'b001000,
    JOB_LQ   = 6'b010000,
    JOB_FLUX = 6'b100000
  } job_t;

  st_t  st_r;
  job_t job_r, job_nxt;

  logic [1:0]  mode_r;
  logic [14:0] uh_r, us_r;
  logic [15:0] settle_r;
  logic [31:0] gain_r;

  logic               start_r;
  logic signed [15:0] id_r, iq_r, we_r;

  logic [2:0]         phase_r, phase_nxt;
  logic [TW-1:0]      wait_r, wait_nxt, rise_r, rise_nxt, wait_tick, rise_tick, long_t;
  logic signed [15:0] half_r, half_nxt, full_r, full_nxt;
  logic [31:0]        res_r, res_nxt, ld_r, lq_r;
  logic signed [31:0] flux_r;
  logic               fault_r, fault_nxt;
  logic signed [15:0] ud_r, ud_nxt, uq_r, uq_nxt;

  logic signed [16:0] diff;
  logic signed [21:0] id_x, iq_x, full_x;
  logic               rise_d, rise_q;

  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [23:0] pp_r;
  logic [31:0] lo_r;
  logic [63:0] l_sum;
  logic [31:0] l_val;

  logic [15:0] abs_iq, abs_we;
  logic signed [49:0] sp, num;
  logic [49:0] mag;
  logic        qneg_r;

  logic                       div_start;
  logic [mpi_pkg::DIV_NUM_W-1:0] div_num, quo;
  logic [mpi_pkg::DIV_DEN_W-1:0] div_den;
  mpi_pkg::div_stat_t         div_stat;
  logic [31:0]                flux_sat;

  logic out_valid_r, out_load;

  assign in_ready  = st_r == S_IDLE;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_load  = (st_r == S_OUT) && (!out_valid_r || out_ready);

  always_comb begin
    wait_tick = (wait_r != '1) ? wait_r + 1'b1 : wait_r;
    rise_tick = (rise_r != '1) ? rise_r + 1'b1 : rise_r;
    long_t    = TW'({settle_r, 3'b0}) + TW'({settle_r, 1'b0});
    diff      = 17'(id_r) - 17'(half_r);
    id_x      = 22'(id_r);
    iq_x      = 22'(iq_r);
    full_x    = 22'(full_r);
    rise_d    = (id_x * 22'sd20) >= (full_x * 22'sd19);
    rise_q    = (iq_x * 22'sd20) >= (full_x * 22'sd19);
  end

  always_comb begin
    phase_nxt = phase_r;
    wait_nxt  = wait_r;
    rise_nxt  = rise_r;
    half_nxt  = half_r;
    full_nxt  = full_r;
    fault_nxt = fault_r;
    res_nxt   = res_r;
    ud_nxt    = '0;
    uq_nxt    = '0;
    job_nxt   = JOB_NONE;
    if (phase_r == mpi_pkg::PH_IDLE || phase_r == mpi_pkg::PH_DONE) begin
      if (start_r && (mode_r == mpi_pkg::MODE_LS || mode_r == mpi_pkg::MODE_LDLQ)) begin
        phase_nxt = mpi_pkg::PH_HALF;
        wait_nxt  = '0;
        fault_nxt = 1'b0;
        ud_nxt    = {2'b0, uh_r[14:1]};
      end else if (start_r && mode_r == mpi_pkg::MODE_FLUX) begin
        phase_nxt = mpi_pkg::PH_FLUX;
        wait_nxt  = '0;
        fault_nxt = 1'b0;
        uq_nxt    = {1'b0, us_r};
      end
    end else if (mode_r == mpi_pkg::MODE_OFF) begin
      phase_nxt = mpi_pkg::PH_IDLE;
      wait_nxt  = '0;
      rise_nxt  = '0;
    end else begin
      unique case (phase_r)
        mpi_pkg::PH_HALF: begin
          wait_nxt = wait_tick;
          if (wait_tick >= TW'(settle_r)) begin
            half_nxt  = id_r;
            phase_nxt = mpi_pkg::PH_FULL;
            wait_nxt  = '0;
            ud_nxt    = {1'b0, uh_r};
          end else begin
            ud_nxt = {2'b0, uh_r[14:1]};
          end
        end
        mpi_pkg::PH_FULL: begin
          wait_nxt = wait_tick;
          if (wait_tick >= TW'(settle_r)) begin
            full_nxt  = id_r;
            phase_nxt = mpi_pkg::PH_PAUSE;
            wait_nxt  = '0;
            if (diff == '0) begin
              fault_nxt = 1'b1;
            end else if (diff < 0) begin
              res_nxt = '0;
            end else begin
              job_nxt = JOB_RS;
            end
          end else begin
            ud_nxt = {1'b0, uh_r};
          end
        end
        mpi_pkg::PH_PAUSE: begin
          wait_nxt = wait_tick;
          if (wait_tick >= long_t) begin
            phase_nxt = mpi_pkg::PH_LD;
            wait_nxt  = '0;
            rise_nxt  = '0;
            ud_nxt    = {1'b0, uh_r};
          end
        end
        mpi_pkg::PH_LD: begin
          rise_nxt = rise_tick;
          if (rise_d) begin
            if (mode_r == mpi_pkg::MODE_LS) begin
              job_nxt   = JOB_LDLQ;
              phase_nxt = mpi_pkg::PH_DONE;
            end else begin
              job_nxt   = JOB_LD;
              phase_nxt = mpi_pkg::PH_LQ;
              uq_nxt    = {1'b0, uh_r};
            end
          end else begin
            ud_nxt = {1'b0, uh_r};
          end
        end
        mpi_pkg::PH_LQ: begin
          rise_nxt = rise_tick;
          if (rise_q) begin
            job_nxt   = JOB_LQ;
            phase_nxt = mpi_pkg::PH_DONE;
          end else begin
            uq_nxt = {1'b0, uh_r};
          end
        end
        default: begin
          wait_nxt = wait_tick;
          if (wait_tick >= long_t) begin
            wait_nxt  = '0;
            phase_nxt = mpi_pkg::PH_DONE;
            if (we_r == '0) begin
              fault_nxt = 1'b1;
            end else begin
              job_nxt = JOB_FLUX;
            end
          end else begin
            uq_nxt = {1'b0, us_r};
          end
        end
      endcase
    end
  end

  always_comb begin
    abs_iq = iq_r[15] ? 16'(-iq_r) : 16'(iq_r);
    abs_we = we_r[15] ? 16'(-we_r) : 16'(we_r);
    mul_a  = res_r;
    mul_b  = 32'(rise_nxt);
    unique case (st_r)
      S_STEP: begin
        if (job_nxt == JOB_FLUX) begin
          mul_a = {16'b0, abs_iq};
          mul_b = res_r;
        end
      end
      S_M2: begin
        mul_a = mul_p[31:0];
        mul_b = gain_r;
      end
      S_M3: begin
        mul_a = {8'b0, pp_r};
        mul_b = gain_r;
      end
      default: begin
      end
    endcase
    l_sum = mul_p + {32'b0, lo_r};
    l_val = (l_sum[63:32] != '0) ? '1 : l_sum[31:0];
    sp    = iq_r[15] ? -$signed({2'b0, mul_p[47:0]}) : $signed({2'b0, mul_p[47:0]});
    num   = $signed({19'b0, us_r, 16'b0}) - sp;
    mag   = num[49] ? 50'(-num) : 50'(num);
    if (qneg_r) begin
      flux_sat = (quo > 48'h80000000) ? 32'h80000000 : 32'(-quo[31:0]);
    end else begin
      flux_sat = (quo > 48'h7FFFFFFF) ? 32'h7FFFFFFF : quo[31:0];
    end
    div_start = 1'b0;
    div_num   = {17'b0, uh_r, 16'b0};
    div_den   = {diff[15:0], 1'b0};
    if (st_r == S_STEP && job_nxt == JOB_RS) begin
      div_start = 1'b1;
    end else if (st_r == S_F2) begin
      div_start = 1'b1;
      div_num   = mag[47:0];
      div_den   = {1'b0, abs_we};
    end
  end

  mpi_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (mul_p)
  );

  mpi_div #(
    .NUM_W (mpi_pkg::DIV_NUM_W),
    .DEN_W (mpi_pkg::DIV_DEN_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .stat  (div_stat),
    .quo   (quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      job_r       <= JOB_NONE;
      mode_r      <= mpi_pkg::MODE_OFF;
      uh_r        <= '0;
      us_r        <= '0;
      settle_r    <= 16'd1000;
      gain_r      <= '0;
      phase_r     <= mpi_pkg::PH_IDLE;
      wait_r      <= '0;
      rise_r      <= '0;
      half_r      <= '0;
      full_r      <= '0;
      res_r       <= '0;
      ld_r        <= '0;
      lq_r        <= '0;
      flux_r      <= '0;
      fault_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          mpi_pkg::CFG_MODE:   mode_r   <= cfg_data[1:0];
          mpi_pkg::CFG_INJECT: uh_r     <= cfg_data[14:0];
          mpi_pkg::CFG_FLUXV:  us_r     <= cfg_data[14:0];
          mpi_pkg::CFG_SETTLE: settle_r <= cfg_data[15:0];
          mpi_pkg::CFG_GAIN:   gain_r   <= cfg_data;
          default: begin
          end
        endcase
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (st_r)
        S_IDLE: begin
          if (in_valid) begin
            start_r <= in_start_req;
            id_r    <= in_current_d;
            iq_r    <= in_current_q;
            we_r    <= in_elec_speed;
            st_r    <= S_STEP;
          end
        end
        S_STEP: begin
          phase_r <= phase_nxt;
          wait_r  <= wait_nxt;
          rise_r  <= rise_nxt;
          half_r  <= half_nxt;
          full_r  <= full_nxt;
          fault_r <= fault_nxt;
          res_r   <= res_nxt;
          ud_r    <= ud_nxt;
          uq_r    <= uq_nxt;
          job_r   <= job_nxt;
          unique case (job_nxt)
            JOB_NONE: st_r <= S_OUT;
            JOB_RS:   st_r <= S_DIV;
            JOB_FLUX: st_r <= S_F2;
            default:  st_r <= S_M2;
          endcase
        end
        S_M2: begin
          pp_r <= mul_p[55:32];
          st_r <= S_M3;
        end
        S_M3: begin
          lo_r <= mul_p[63:32];
          st_r <= S_M4;
        end
        S_M4: begin
          rise_r <= '0;
          if (job_r != JOB_LQ) begin
            ld_r <= l_val;
          end
          if (job_r != JOB_LD) begin
            lq_r <= l_val;
          end
          st_r <= S_OUT;
        end
        S_F2: begin
          qneg_r <= num[49] ^ we_r[15];
          st_r   <= S_DIV;
        end
        S_DIV: begin
          if (div_stat.done) begin
            st_r <= S_DIVEND;
          end
        end
        S_DIVEND: begin
          if (job_r == JOB_RS) begin
            res_r <= quo[31:0];
          end else begin
            flux_r <= flux_sat;
          end
          st_r <= S_OUT;
        end
        default: begin
          if (out_load) begin
            st_r <= S_IDLE;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_volt_d_cmd   <= ud_r;
      out_volt_q_cmd   <= uq_r;
      out_phase        <= phase_r;
      out_done_res     <= phase_r == mpi_pkg::PH_DONE;
      out_fault        <= fault_r;
      out_resistance   <= res_r;
      out_induct_d     <= ld_r;
      out_induct_q     <= lq_r;
      out_flux_linkage <= flux_r;
    end
  end

  `MPI_ASSERT(a_idle_counters_clear, (phase_r == mpi_pkg::PH_IDLE) |-> (wait_r == '0 && rise_r == '0), "Counters not clear in idle phase.")
  `MPI_ASSERT(a_div_only_in_div, div_stat.busy |-> (st_r == S_DIV), "Divider running outside the divide state.")
  `MPI_ASSERT(a_no_accept_in_work, (st_r != S_IDLE) |-> !in_ready, "Word accepted while a step is in work.")
endmodule
`default_nettype wire
